>>> rtl/cab_pkg.sv
// Package for the cabinet filter: sizes, coefficient and gain tables, microcode.
package cab_pkg;

	localparam int SECTIONS    = 14;
	localparam int SAMPLE_BITS = 24;
	localparam int ROM_ROWS    = 14;
	localparam int NCOEF       = 5;

	localparam int DATA_W  = 32;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int ACC_W   = 38;
	localparam int GAIN_W  = 21;
	localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int UPC_W   = 4;
	localparam int FRAC_Q  = 29;
	localparam int IN_SHIFT  = 30 - SAMPLE_BITS;
	localparam int OUT_SHIFT = 46 - SAMPLE_BITS;

	// b0, b1, b2, a1, a2 per row, as decimals scaled by 1e7
	localparam int DEC_TAB [ROM_ROWS*NCOEF] = '{
		7766541,  -12730632, 4964157, -17804153, 7822079,
		6396814,  -12730632, 6351665, -13209846, 3340182,
		6930719,  -7139052,  3888366, -19880411, 9908078,
		5757927,  -10729329, 5622981, -12883548, 4063247,
		6829763,  -12730632, 5900877, -18641577, 9665362,
		6852150,  -12730632, 6096407, -14141491, 8493963,
		8642277,  -12730632, 8004165, -12550898, 8431984,
		12730632, 4251560,   6279134, 6219096,   473852,
		12730632, 10594001,  2203776, -3286332,  1031611,
		12730632, 11460023,  2064885, -12492166, 3501117,
		10366086, -12730632, 5341168, -300188,   4770231,
		12730632, -1485291,  8781998, -10789590, 3182753,
		7276214,  -6799656,  5286805, 7840933,   1197370,
		3329179,  1390787,   0,       -7374847,  0
	};

	typedef logic [SECTIONS-1:0][NCOEF-1:0][DATA_W-1:0] coef_tab_t;
	typedef logic [255:0][GAIN_W-1:0] gain_tab_t;

	// nearest Q3.29 value, ties away from zero
	function automatic logic [DATA_W-1:0] cq_f(input longint k);
		longint r;
		begin
			if (k < 0)
				r = -(((-k) * 64'sd536870912 + 64'sd5000000) / 64'sd10000000);
			else
				r = (k * 64'sd536870912 + 64'sd5000000) / 64'sd10000000;
			return r[DATA_W-1:0];
		end
	endfunction

	function automatic coef_tab_t build_coef_tab();
		coef_tab_t t;
		begin
			for (int s = 0; s < SECTIONS; s++) begin
				for (int c = 0; c < NCOEF; c++) begin
					if (s < ROM_ROWS)
						t[s][c] = cq_f(longint'(DEC_TAB[s*NCOEF + c]));
					else if (c == 0)
						t[s][c] = DATA_W'(64'sd1 <<< FRAC_Q);
					else
						t[s][c] = '0;
				end
			end
			return t;
		end
	endfunction

	// Q5.16 gain = round(20 * knob^2 / 65025), ties up
	function automatic gain_tab_t build_gain_tab();
		gain_tab_t t;
		longint v;
		begin
			for (int i = 0; i < 256; i++) begin
				v = (longint'(20) * i * i * 65536 + 32512) / 65025;
				t[i] = v[GAIN_W-1:0];
			end
			return t;
		end
	endfunction

	localparam coef_tab_t COEF_TAB = build_coef_tab();
	localparam gain_tab_t GAIN_TAB = build_gain_tab();

	typedef enum logic [2:0] {
		PAIR_B0X0 = 3'd0,
		PAIR_B1X1 = 3'd1,
		PAIR_B2X2 = 3'd2,
		PAIR_A1Y1 = 3'd3,
		PAIR_A2Y2 = 3'd4,
		PAIR_GCUR = 3'd5
	} pair_t;

	typedef enum logic [1:0] {
		ACC_NONE = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		BR_NEXT = 2'd0,
		BR_SEC  = 2'd1,
		BR_END  = 2'd2
	} br_t;

	typedef struct packed {
		logic    mul;
		pair_t   pair;
		acc_op_t acc_op;
		logic    rnd_out;
		logic    wb;
		logic    out;
		br_t     br;
	} uop_t;

	localparam uop_t UOP_NOP = '{mul: 1'b0, pair: PAIR_B0X0, acc_op: ACC_NONE,
		rnd_out: 1'b0, wb: 1'b0, out: 1'b0, br: BR_NEXT};

	// Program: five MACs per section, pipeline drain, write-back and loop,
	// then the gain multiply and the output step.
	function automatic uop_t ucode_f(input logic [UPC_W-1:0] pc);
		uop_t u;
		begin
			u = UOP_NOP;
			unique case (pc)
				4'd0: begin u.mul = 1'b1; u.pair = PAIR_B0X0; u.acc_op = ACC_LOAD; end
				4'd1: begin u.mul = 1'b1; u.pair = PAIR_B1X1; u.acc_op = ACC_ADD; end
				4'd2: begin u.mul = 1'b1; u.pair = PAIR_B2X2; u.acc_op = ACC_ADD; end
				4'd3: begin u.mul = 1'b1; u.pair = PAIR_A1Y1; u.acc_op = ACC_SUB; end
				4'd4: begin u.mul = 1'b1; u.pair = PAIR_A2Y2; u.acc_op = ACC_SUB; end
				4'd5, 4'd6, 4'd9, 4'd10: u = UOP_NOP;
				4'd7: begin u.wb = 1'b1; u.br = BR_SEC; end
				4'd8: begin
					u.mul = 1'b1; u.pair = PAIR_GCUR; u.acc_op = ACC_LOAD; u.rnd_out = 1'b1;
				end
				4'd11: begin u.out = 1'b1; u.br = BR_END; end
				default: u = UOP_NOP;
			endcase
			return u;
		end
	endfunction

endpackage

>>> rtl/cascaded_biquad_cab_filter.sv
// Top level: microcoded biquad cascade with output gain, one shared multiplier.
// The single multiply-accumulate unit runs 8 microcode steps per section.
// Input stalls while a sample is in the datapath; a finished result waits in the
// output register. Reset clears the filter history, the gain (muted) and control.
module cascaded_biquad_cab_filter
	import cab_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] MIN32 = ACC_W'(-64'sd2147483648);
	localparam logic signed [ACC_W-1:0] MAXS  = ACC_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
	localparam logic signed [ACC_W-1:0] MINS  = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS-1)));
	localparam logic signed [PROD_W-1:0] HALF_Q  = PROD_W'(64'sd1 <<< (FRAC_Q-1));
	localparam logic signed [PROD_W-1:0] HALF_O  = PROD_W'(64'sd1 <<< (OUT_SHIFT-1));

	logic                     busy_q;
	logic [UPC_W-1:0]         upc_q;
	logic [SEC_W-1:0]         sec_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] x1_q [SECTIONS];
	logic signed [DATA_W-1:0] x2_q [SECTIONS];
	logic signed [DATA_W-1:0] y1_q [SECTIONS];
	logic signed [DATA_W-1:0] y2_q [SECTIONS];

	logic signed [DATA_W-1:0] opa_s1, opb_s1;
	acc_op_t                  op_s1, op_s2;
	logic                     rnd_s1, rnd_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	uop_t                     uop;
	logic                     in_fire;
	logic                     out_fire;
	logic                     out_free;
	logic                     last_sec;
	logic signed [PROD_W-1:0] sum_q, sum_o;
	logic signed [ACC_W-1:0]  term;
	logic signed [DATA_W-1:0] acc_sat32;
	logic signed [SAMPLE_BITS-1:0] acc_sat_out;
	logic signed [DATA_W-1:0] sel_a, sel_b;
	logic [NCOEF-1:0][DATA_W-1:0] coef_row;

	assign uop      = ucode_f(upc_q);
	assign in_stall = busy_q;
	assign in_fire  = in_valid && !busy_q;
	assign out_fire = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last_sec = (sec_q == SEC_W'(SECTIONS - 1));
	assign coef_row = COEF_TAB[sec_q];

	// product rounding: half up to Q3.29, or to the output sample format
	assign sum_q = prod_s2 + HALF_Q;
	assign sum_o = prod_s2 + HALF_O;
	assign term  = rnd_s2 ? ACC_W'(signed'(sum_o[PROD_W-1:OUT_SHIFT]))
	                      : ACC_W'(signed'(sum_q[PROD_W-1:FRAC_Q]));

	always_comb begin
		if (acc_q > MAX32)
			acc_sat32 = DATA_W'(MAX32);
		else if (acc_q < MIN32)
			acc_sat32 = DATA_W'(MIN32);
		else
			acc_sat32 = DATA_W'(acc_q);
	end

	always_comb begin
		if (acc_q > MAXS)
			acc_sat_out = SAMPLE_BITS'(MAXS);
		else if (acc_q < MINS)
			acc_sat_out = SAMPLE_BITS'(MINS);
		else
			acc_sat_out = SAMPLE_BITS'(acc_q);
	end

	always_comb begin
		unique case (uop.pair)
			PAIR_B0X0: begin sel_a = cur_q;        sel_b = signed'(coef_row[0]); end
			PAIR_B1X1: begin sel_a = x1_q[sec_q];  sel_b = signed'(coef_row[1]); end
			PAIR_B2X2: begin sel_a = x2_q[sec_q];  sel_b = signed'(coef_row[2]); end
			PAIR_A1Y1: begin sel_a = y1_q[sec_q];  sel_b = signed'(coef_row[3]); end
			PAIR_A2Y2: begin sel_a = y2_q[sec_q];  sel_b = signed'(coef_row[4]); end
			PAIR_GCUR: begin sel_a = cur_q;        sel_b = signed'(DATA_W'(gain_q)); end
			default:   begin sel_a = cur_q;        sel_b = '0; end
		endcase
	end

	// gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (cfg_we) begin
			gain_q <= GAIN_TAB[cfg_data];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= '0;
			sec_q  <= '0;
		end else if (!busy_q) begin
			if (in_fire) begin
				busy_q <= 1'b1;
				upc_q  <= '0;
				sec_q  <= '0;
			end
		end else begin
			unique case (uop.br)
				BR_NEXT: upc_q <= upc_q + 1'b1;
				BR_SEC: begin
					if (last_sec) begin
						upc_q <= upc_q + 1'b1;
					end else begin
						upc_q <= '0;
						sec_q <= sec_q + 1'b1;
					end
				end
				BR_END: begin
					if (out_free)
						busy_q <= 1'b0;
				end
				default: upc_q <= upc_q;
			endcase
		end
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= ACC_NONE;
			op_s2 <= ACC_NONE;
		end else begin
			op_s1 <= (busy_q && uop.mul) ? uop.acc_op : ACC_NONE;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		opa_s1  <= sel_a;
		opb_s1  <= sel_b;
		rnd_s1  <= uop.rnd_out;
		rnd_s2  <= rnd_s1;
		prod_s2 <= opa_s1 * opb_s1;
		unique case (op_s2)
			ACC_LOAD: acc_q <= term;
			ACC_ADD:  acc_q <= acc_q + term;
			ACC_SUB:  acc_q <= acc_q - term;
			default:  acc_q <= acc_q;
		endcase
	end

	// section input and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			for (int i = 0; i < SECTIONS; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else if (in_fire) begin
			cur_q <= DATA_W'(sample_in) <<< IN_SHIFT;
		end else if (busy_q && uop.wb) begin
			x2_q[sec_q] <= x1_q[sec_q];
			x1_q[sec_q] <= cur_q;
			y2_q[sec_q] <= y1_q[sec_q];
			y1_q[sec_q] <= acc_sat32;
			cur_q       <= acc_sat32;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_q && uop.out && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && uop.out && out_free)
			sample_out_q <= acc_sat_out;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

>>> rtl/cab_checker.sv
// Port-level checker for the cabinet filter, bound to the top level.
module cab_checker
	import cab_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [7:0]                    cfg_data,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_out
);

	logic knob_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_zero_q <= 1'b1;
		end else if (cfg_we) begin
			knob_zero_q <= (cfg_data == 8'd0);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("result changed while stalled");

	// an accepted sample puts the input side into stall
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transaction");

	// a new result only comes out of a sample in flight
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a sample in flight");

	// zero level mutes the output
	a_mute: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && knob_zero_q |-> sample_out == '0)
		else $error("output not muted at zero level");

endmodule

bind cascaded_biquad_cab_filter cab_checker u_cab_checker (.*);

>>> test/cascaded_biquad_cab_filter_test.sv
// Self-checking testbench for the cabinet biquad cascade: directed plan, then random phases.
module cascaded_biquad_cab_filter_test;
	import cab_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 130;
	localparam int CHUNK_ITEMS  = 150;
	localparam int NSEC         = 14;

	// b0, b1, b2, a1, a2 per section, decimal scaled by 1e7
	localparam int CAB_DEC [NSEC][5] = '{
		'{7766541,  -12730632, 4964157, -17804153, 7822079},
		'{6396814,  -12730632, 6351665, -13209846, 3340182},
		'{6930719,  -7139052,  3888366, -19880411, 9908078},
		'{5757927,  -10729329, 5622981, -12883548, 4063247},
		'{6829763,  -12730632, 5900877, -18641577, 9665362},
		'{6852150,  -12730632, 6096407, -14141491, 8493963},
		'{8642277,  -12730632, 8004165, -12550898, 8431984},
		'{12730632, 4251560,   6279134, 6219096,   473852},
		'{12730632, 10594001,  2203776, -3286332,  1031611},
		'{12730632, 11460023,  2064885, -12492166, 3501117},
		'{10366086, -12730632, 5341168, -300188,   4770231},
		'{12730632, -1485291,  8781998, -10789590, 3182753},
		'{7276214,  -6799656,  5286805, 7840933,   1197370},
		'{3329179,  1390787,   0,       -7374847,  0}
	};

	// -1 picks a random knob
	localparam int KNOB_STEPS [9] = '{255, 0, -1, 254, 1, -1, 200, 37, 255};

	typedef struct packed {
		bit                     is_knob;
		logic [7:0]             knob;
		logic [SAMPLE_BITS-1:0] smp;
		bit                     typed;
		logic [SAMPLE_BITS-1:0] want;
	} plan_row_t;

	// muted rows right after reset must read zero
	localparam plan_row_t PLAN [23] = '{
		'{1'b0, 8'd0,   24'h000000, 1'b1, 24'h000000},
		'{1'b0, 8'd0,   24'h7FFFFF, 1'b1, 24'h000000},
		'{1'b0, 8'd0,   24'h800000, 1'b1, 24'h000000},
		'{1'b0, 8'd0,   24'h000001, 1'b1, 24'h000000},
		'{1'b1, 8'd255, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h7FFFFF, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h800000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h7FFFFF, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h800000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h000000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h000001, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'hFFFFFF, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h555555, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'hAAAAAA, 1'b0, 24'h000000},
		'{1'b1, 8'd1,   24'h000000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h400000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'hC00000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h000000, 1'b0, 24'h000000},
		'{1'b1, 8'd128, 24'h000000, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h123456, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'hEDCBAA, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h7FFFFF, 1'b0, 24'h000000},
		'{1'b0, 8'd0,   24'h000000, 1'b0, 24'h000000}
	};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [7:0]                    cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	logic signed [31:0]     coef_q [NSEC][5];
	logic signed [31:0]     x_hist [2*NSEC] = '{default: '0};
	logic signed [31:0]     y_hist [2*NSEC] = '{default: '0};
	logic [7:0]             knob_setting = '0;
	logic [SAMPLE_BITS-1:0] expected_samples [$];
	int                     send_idle_pct  = 0;
	int                     recv_stall_pct = 0;
	int                     mismatches     = 0;
	int                     quiet_cycles   = 0;

	cascaded_biquad_cab_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// coefficient times Q3.29 value, rounded half up back to Q3.29
	function automatic longint q29_mul(input logic signed [31:0] c, input logic signed [31:0] v);
		longint p;
		p = longint'(c) * longint'(v);
		return (p + (longint'(1) <<< 28)) >>> 29;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// advances the cascade history by one sample and returns the gained output
	function automatic logic [SAMPLE_BITS-1:0] run_cabinet(input logic signed [SAMPLE_BITS-1:0] smp);
		longint             cur;
		longint             acc;
		longint             gain;
		longint             kn;
		logic signed [31:0] x0;
		int                 s;
		int                 h;
		cur = longint'(smp) <<< (30 - SAMPLE_BITS);
		for (s = 0; s < NSEC; s++) begin
			h = 2 * s;
			x0 = cur[31:0];
			acc = q29_mul(coef_q[s][0], x0) + q29_mul(coef_q[s][1], x_hist[h])
				+ q29_mul(coef_q[s][2], x_hist[h+1]) - q29_mul(coef_q[s][3], y_hist[h])
				- q29_mul(coef_q[s][4], y_hist[h+1]);
			acc = clip(acc, -64'sd2147483648, 64'sd2147483647);
			x_hist[h+1] = x_hist[h];
			x_hist[h] = x0;
			y_hist[h+1] = y_hist[h];
			y_hist[h] = acc[31:0];
			cur = acc;
		end
		kn = longint'(knob_setting);
		gain = (20 * kn * kn * 65536 + 32512) / 65025;
		acc = (cur * gain + (longint'(1) <<< (45 - SAMPLE_BITS))) >>> (46 - SAMPLE_BITS);
		acc = clip(acc, -(longint'(1) <<< (SAMPLE_BITS-1)), (longint'(1) <<< (SAMPLE_BITS-1)) - 1);
		return acc[SAMPLE_BITS-1:0];
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit typed,
			input logic [SAMPLE_BITS-1:0] want);
		logic [SAMPLE_BITS-1:0] model_out;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= smp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		model_out = run_cabinet(smp);
		expected_samples.push_back(typed ? want : model_out);
	endtask

	// knob changes only with the datapath empty
	task automatic set_knob(input logic [7:0] k);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		knob_setting = k;
	endtask

	always @(posedge clk) begin
		logic [SAMPLE_BITS-1:0] want;
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				$display("%0t unexpected transaction: sample_out expected none actual %0d",
					$time, sample_out);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					$display("%0t sample_out mismatch: expected %0d actual %0d",
						$time, $signed(want), sample_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
				$display("cascaded_biquad_cab_filter test failed");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t                     row;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic signed [SAMPLE_BITS-1:0] prev;
		longint                        d;
		longint                        q;
		int                            k;
		int                            phase;
		int                            chunk;
		int                            n;
		for (int s = 0; s < NSEC; s++) begin
			for (int c = 0; c < 5; c++) begin
				d = CAB_DEC[s][c];
				if (d < 0)
					q = -(((-d) * 536870912 + 5000000) / 10000000);
				else
					q = (d * 536870912 + 5000000) / 10000000;
				coef_q[s][c] = q[31:0];
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			row = PLAN[i];
			if (row.is_knob)
				set_knob(row.knob);
			else
				send_sample(row.smp, row.typed, row.want);
		end

		prev = '0;
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 28 : ((phase == 1) ? 62 : 0);
			recv_stall_pct = (phase == 0) ? 62 : ((phase == 1) ? 28 : 0);
			for (chunk = 0; chunk < 3; chunk++) begin
				k = KNOB_STEPS[phase*3 + chunk];
				set_knob((k < 0) ? 8'($urandom_range(0, 255)) : 8'(k));
				for (n = 0; n < CHUNK_ITEMS; n++) begin
					case ($urandom_range(0, 9))
						0: begin
							case ($urandom_range(0, 2))
								0: smp = 24'sh7FFFFF;
								1: smp = 24'sh800000;
								default: smp = '0;
							endcase
						end
						1: smp = prev;  // held value pushes the cascade toward saturation
						2, 3, 4: smp = SAMPLE_BITS'($urandom);
						default: smp = $signed(SAMPLE_BITS'($urandom)) >>> $urandom_range(1, 20);
					endcase
					send_sample(smp, 1'b0, '0);
					prev = smp;
				end
			end
		end
		in_valid <= 1'b0;

		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("cascaded_biquad_cab_filter test passed");
		else
			$display("cascaded_biquad_cab_filter test failed");
		$finish;
	end

endmodule
